[hw/rtl/sorted_list_engine_core_assert.svh]
// Assertion macros shared by the sorted list engine RTL.
`ifndef SORTED_LIST_ENGINE_CORE_ASSERT_SVH
`define SORTED_LIST_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SLE_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLE_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sle_pkg.sv]
`timescale 1ns / 1ps

package sle_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DATA_W       = 32;
  localparam int CMD_W        = 3;
  localparam int STATUS_W     = 2;
  localparam int LEFT_W       = 6;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SHOW   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  // Operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CMP,
    OP_INS,
    OP_DEL,
    OP_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  val;
  } cell_ctrl_t;

endpackage

[hw/rtl/sle_cell.sv]
`timescale 1ns / 1ps

// One slot of the sorted chain. Holds one entry and its compare flags,
// and trades entries with its neighbors on insert, delete and rotate.
module sle_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  logic                               clk,
  input  sle_pkg::cell_ctrl_t                ctrl,
  input  logic [CNT_W-1:0]                   count,
  input  logic signed [sle_pkg::DATA_W-1:0]  left_entry,
  input  logic                               left_lt,
  input  logic signed [sle_pkg::DATA_W-1:0]  right_entry,
  input  logic signed [sle_pkg::DATA_W-1:0]  head_entry,
  output logic signed [sle_pkg::DATA_W-1:0]  entry,
  output logic                               lt,
  output logic                               eq
);

  logic signed [sle_pkg::DATA_W-1:0] entry_r;
  logic                              lt_r;
  logic                              eq_r;
  logic                              slot_valid;
  logic                              is_tail;

  assign slot_valid = CNT_W'(IDX) < count;
  assign is_tail    = CNT_W'(IDX) == (count - 1'b1);

  // lt: entry is strictly below the operand; the chain is a run of ones from the head
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      sle_pkg::OP_CMP: begin
        lt_r <= slot_valid && (entry_r < ctrl.val);
        eq_r <= slot_valid && (entry_r == ctrl.val);
      end
      sle_pkg::OP_INS: begin
        // first non-smaller slot takes the value, the ones after shift right
        if (!lt_r) begin
          if (left_lt) entry_r <= ctrl.val;
          else entry_r <= left_entry;
        end
      end
      sle_pkg::OP_DEL: begin
        // first non-smaller slot is the match; it and the tail shift left
        if (!lt_r) entry_r <= right_entry;
      end
      sle_pkg::OP_ROT: begin
        entry_r <= is_tail ? head_entry : right_entry;
      end
      default: ;
    endcase
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

[hw/rtl/sorted_list_engine_core.sv]
`timescale 1ns / 1ps

// Sorted list engine: keeps up to CAPACITY signed 32-bit values in ascending
// order, duplicates allowed, in a chain of cells (one entry per cell).
// Input channel in_valid/in_ready carries one command beat (in_cmd, in_value):
// insert, show, search, delete first match, clear. Unknown codes are dropped.
// Output channel out_valid/out_ready carries result beats with status, item,
// entries_left and last. Insert, search and delete give one beat; show and
// clear give one beat per entry from the head, last set on the final one;
// on an empty list they give a single empty-status beat.
// Sequence: a command beat is taken in S_IDLE, the cells compare in S_CMP,
// and in S_EXEC, once the result register is free, the list is updated and
// the result registered. Show and clear then step through S_EMIT, one beat
// per entry, as the chain rotates the next entry to the head.
// A stalled receiver holds the result register; the chain waits with it and
// a single pending result does not block the next command from being taken.
// Reset (rst_n low, synchronous) empties the list and drops pending results.
module sorted_list_engine_core #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [sle_pkg::CMD_W-1:0]            in_cmd,
  input  logic signed [sle_pkg::DATA_W-1:0]    in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sle_pkg::STATUS_W-1:0]         out_status,
  output logic signed [sle_pkg::DATA_W-1:0]    out_item,
  output logic [sle_pkg::LEFT_W-1:0]           out_entries_left,
  output logic                                 out_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC,
    S_EMIT
  } state_t;

  state_t                               state_r;
  logic [sle_pkg::CMD_W-1:0]            cmd_r;
  logic signed [sle_pkg::DATA_W-1:0]    val_r;
  logic [CNT_W-1:0]                     count_r;
  logic [CNT_W-1:0]                     idx_r;
  logic                                 out_valid_r;
  logic [sle_pkg::STATUS_W-1:0]         status_r;
  logic signed [sle_pkg::DATA_W-1:0]    item_r;
  logic [sle_pkg::LEFT_W-1:0]           left_r;
  logic                                 last_r;

  sle_pkg::cell_ctrl_t                  cell_ctrl;
  logic signed [sle_pkg::DATA_W-1:0]    entry_w [CAPACITY];
  logic [CAPACITY-1:0]                  lt_w;
  logic [CAPACITY-1:0]                  eq_w;

  logic slot_free;
  logic full;
  logic found;
  logic emit_last;
  logic out_load;
  logic ins_op;

  // Count as a 6-bit result field, masked or zero-extended
  function automatic logic [sle_pkg::LEFT_W-1:0] to_left(input logic [CNT_W-1:0] c);
    logic [CNT_W+sle_pkg::LEFT_W-1:0] w;
    w = {{sle_pkg::LEFT_W{1'b0}}, c};
    return w[sle_pkg::LEFT_W-1:0];
  endfunction

  assign slot_free = !out_valid_r || out_ready;
  assign full      = count_r == CNT_W'(CAPACITY);
  assign found     = |eq_w;
  assign emit_last = idx_r == (count_r - 1'b1);
  assign ins_op    = cell_ctrl.op == sle_pkg::OP_INS;

  // A result beat is loaded this cycle
  assign out_load = slot_free && (state_r == S_EMIT || (state_r == S_EXEC &&
                    (cmd_r == sle_pkg::CMD_INSERT || cmd_r == sle_pkg::CMD_SEARCH ||
                     cmd_r == sle_pkg::CMD_DELETE ||
                     ((cmd_r == sle_pkg::CMD_SHOW || cmd_r == sle_pkg::CMD_CLEAR) &&
                      count_r == '0))));

  // Operation broadcast to the chain
  always_comb begin
    cell_ctrl.op  = sle_pkg::OP_HOLD;
    cell_ctrl.val = val_r;
    unique case (state_r)
      S_CMP: cell_ctrl.op = sle_pkg::OP_CMP;
      S_EXEC: begin
        if (slot_free && cmd_r == sle_pkg::CMD_INSERT && !full)
          cell_ctrl.op = sle_pkg::OP_INS;
        else if (slot_free && cmd_r == sle_pkg::CMD_DELETE && found)
          cell_ctrl.op = sle_pkg::OP_DEL;
      end
      S_EMIT: if (slot_free) cell_ctrl.op = sle_pkg::OP_ROT;
      default: ;
    endcase
  end

  // Chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [sle_pkg::DATA_W-1:0] left_e;
    logic                              left_l;
    logic signed [sle_pkg::DATA_W-1:0] right_e;

    if (i == 0) begin : g_head
      assign left_e = val_r;
      assign left_l = 1'b1;
    end else begin : g_body
      assign left_e = entry_w[i-1];
      assign left_l = lt_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = entry_w[i];
    end else begin : g_mid
      assign right_e = entry_w[i+1];
    end

    sle_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl),
      .count       (count_r),
      .left_entry  (left_e),
      .left_lt     (left_l),
      .right_entry (right_e),
      .head_entry  (entry_w[0]),
      .entry       (entry_w[i]),
      .lt          (lt_w[i]),
      .eq          (eq_w[i])
    );
  end

  // Sequencer, list count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_cmd;
            val_r   <= in_value;
            state_r <= S_CMP;
          end
        end
        S_CMP: state_r <= S_EXEC;
        S_EXEC: begin
          if (slot_free) begin
            state_r <= S_IDLE;
            unique case (cmd_r)
              sle_pkg::CMD_INSERT: begin
                item_r      <= val_r;
                last_r      <= 1'b1;
                if (full) begin
                  status_r <= sle_pkg::ST_FULL;
                  left_r   <= to_left(count_r);
                end else begin
                  status_r <= sle_pkg::ST_OK;
                  left_r   <= to_left(count_r + 1'b1);
                  count_r  <= count_r + 1'b1;
                end
              end
              sle_pkg::CMD_SEARCH: begin
                item_r      <= val_r;
                last_r      <= 1'b1;
                left_r      <= to_left(count_r);
                status_r    <= found ? sle_pkg::ST_OK : sle_pkg::ST_NOTFOUND;
              end
              sle_pkg::CMD_DELETE: begin
                item_r      <= val_r;
                last_r      <= 1'b1;
                if (count_r == '0) begin
                  status_r <= sle_pkg::ST_EMPTY;
                  left_r   <= to_left(count_r);
                end else if (found) begin
                  status_r <= sle_pkg::ST_OK;
                  left_r   <= to_left(count_r - 1'b1);
                  count_r  <= count_r - 1'b1;
                end else begin
                  status_r <= sle_pkg::ST_NOTFOUND;
                  left_r   <= to_left(count_r);
                end
              end
              sle_pkg::CMD_SHOW, sle_pkg::CMD_CLEAR: begin
                if (count_r == '0) begin
                  status_r    <= sle_pkg::ST_EMPTY;
                  item_r      <= '0;
                  left_r      <= '0;
                  last_r      <= 1'b1;
                end else begin
                  idx_r   <= '0;
                  state_r <= S_EMIT;
                end
              end
              default: ;
            endcase
          end
        end
        S_EMIT: begin
          // one entry per beat from the head; the chain rotates it to the tail
          if (slot_free) begin
            status_r    <= sle_pkg::ST_OK;
            item_r      <= entry_w[0];
            last_r      <= emit_last;
            left_r      <= (cmd_r == sle_pkg::CMD_CLEAR) ? '0 : to_left(count_r);
            idx_r       <= idx_r + 1'b1;
            if (emit_last) begin
              state_r <= S_IDLE;
              if (cmd_r == sle_pkg::CMD_CLEAR) count_r <= '0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready         = state_r == S_IDLE;
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_item         = item_r;
  assign out_entries_left = left_r;
  assign out_last         = last_r;

`include "sorted_list_engine_core_assert.svh"

  `SLE_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY), "count overflow")
  `SLE_ASSERT_NXT(a_ins_grows, clk, rst_n, ins_op, count_r == $past(count_r) + 1'b1, "insert lost")
  `SLE_ASSERT_IMP(a_emit_nonempty, clk, rst_n, state_r == S_EMIT, count_r != '0, "empty emit")

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int CAP         = sle_pkg::CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 10;

  localparam logic signed [sle_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [sle_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // codes past clear are not commands; the block must swallow them
  localparam logic [sle_pkg::CMD_W-1:0] CMD_UNKNOWN_LO = sle_pkg::CMD_CLEAR + 1'b1;
  localparam logic [sle_pkg::CMD_W-1:0] CMD_UNKNOWN_HI = '1;

  typedef struct {
    logic [sle_pkg::STATUS_W-1:0]      status;
    logic signed [sle_pkg::DATA_W-1:0] item;
    logic [sle_pkg::LEFT_W-1:0]        left;
    logic                              last;
  } result_beat_t;

  // Shadow of the sorted table plus the queue of result beats still owed
  class list_scoreboard;
    logic signed [sle_pkg::DATA_W-1:0] shadow [CAP];
    int unsigned                       shadow_cnt;
    result_beat_t                      beats_due [$];
    int unsigned                       fail_cnt;

    function new();
      shadow_cnt = 0;
      fail_cnt   = 0;
    endfunction

    function void note_fail(string msg);
      fail_cnt++;
      if (fail_cnt <= REPORT_MAX) $display("%s", msg);
    endfunction

    function int unsigned pending();
      return beats_due.size();
    endfunction

    function void push_beat(logic [sle_pkg::STATUS_W-1:0] st,
                            logic signed [sle_pkg::DATA_W-1:0] it, logic lst);
      result_beat_t b;
      b.status = st;
      b.item   = it;
      b.left   = sle_pkg::LEFT_W'(shadow_cnt);
      b.last   = lst;
      beats_due.push_back(b);
    endfunction

    function int find_first(logic signed [sle_pkg::DATA_W-1:0] val);
      for (int k = 0; k < shadow_cnt; k++)
        if (shadow[k] == val) return k;
      return -1;
    endfunction

    // random member of the table, or any value when it is empty
    function logic signed [sle_pkg::DATA_W-1:0] pick_entry();
      if (shadow_cnt == 0) return $urandom;
      return shadow[$urandom_range(0, shadow_cnt - 1)];
    endfunction

    // Update the shadow table for one accepted command beat
    function void note_command(logic [sle_pkg::CMD_W-1:0] cmd,
                               logic signed [sle_pkg::DATA_W-1:0] val);
      int unsigned pos;
      int unsigned n;
      int hit;
      case (cmd)
        sle_pkg::CMD_INSERT: begin
          if (shadow_cnt >= CAP) begin
            push_beat(sle_pkg::ST_FULL, val, 1'b1);
          end else begin
            pos = 0;
            while (pos < shadow_cnt && shadow[pos] < val) pos++;
            for (int unsigned k = shadow_cnt; k > pos; k--) shadow[k] = shadow[k-1];
            shadow[pos] = val;
            shadow_cnt++;
            push_beat(sle_pkg::ST_OK, val, 1'b1);
          end
        end
        sle_pkg::CMD_SHOW: begin
          if (shadow_cnt == 0) push_beat(sle_pkg::ST_EMPTY, '0, 1'b1);
          else
            for (int unsigned k = 0; k < shadow_cnt; k++)
              push_beat(sle_pkg::ST_OK, shadow[k], k + 1 == shadow_cnt);
        end
        sle_pkg::CMD_SEARCH: begin
          push_beat(find_first(val) >= 0 ? sle_pkg::ST_OK : sle_pkg::ST_NOTFOUND, val, 1'b1);
        end
        sle_pkg::CMD_DELETE: begin
          hit = find_first(val);
          if (shadow_cnt == 0) begin
            push_beat(sle_pkg::ST_EMPTY, val, 1'b1);
          end else if (hit < 0) begin
            push_beat(sle_pkg::ST_NOTFOUND, val, 1'b1);
          end else begin
            for (int unsigned k = hit; k + 1 < shadow_cnt; k++) shadow[k] = shadow[k+1];
            shadow_cnt--;
            push_beat(sle_pkg::ST_OK, val, 1'b1);
          end
        end
        sle_pkg::CMD_CLEAR: begin
          if (shadow_cnt == 0) begin
            push_beat(sle_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            // every clear beat reports the post-clear count of zero
            n = shadow_cnt;
            shadow_cnt = 0;
            for (int unsigned k = 0; k < n; k++)
              push_beat(sle_pkg::ST_OK, shadow[k], k + 1 == n);
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result beat with the oldest one owed
    function void check_beat(logic [sle_pkg::STATUS_W-1:0] st,
                             logic signed [sle_pkg::DATA_W-1:0] it,
                             logic [sle_pkg::LEFT_W-1:0] lf, logic lst);
      result_beat_t want;
      if (beats_due.size() == 0) begin
        note_fail($sformatf("unexpected beat: st=%0d item=%0d left=%0d last=%0b",
                            st, it, lf, lst));
        return;
      end
      want = beats_due.pop_front();
      if (want.status !== st || want.item !== it || want.left !== lf || want.last !== lst)
        note_fail($sformatf({"beat mismatch: want st=%0d item=%0d left=%0d last=%0b,",
                             " got st=%0d item=%0d left=%0d last=%0b"},
                            want.status, want.item, want.left, want.last,
                            st, it, lf, lst));
    endfunction
  endclass

  logic                              clk       = 1'b0;
  logic                              rst_n     = 1'b0;
  logic                              in_valid  = 1'b0;
  logic                              in_ready;
  logic [sle_pkg::CMD_W-1:0]         in_cmd    = '0;
  logic signed [sle_pkg::DATA_W-1:0] in_value  = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [sle_pkg::STATUS_W-1:0]      out_status;
  logic signed [sle_pkg::DATA_W-1:0] out_item;
  logic [sle_pkg::LEFT_W-1:0]        out_entries_left;
  logic                              out_last;

  list_scoreboard sb;
  logic           idle_en    = 1'b1;
  int             stall_left = 0;
  int             cycles     = 0;

  sorted_list_engine_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_item         (out_item),
    .out_entries_left (out_entries_left),
    .out_last         (out_last)
  );

  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Receiver back-pressure: random bursts of deasserted out_ready
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ready  <= 1'b0;
    end else begin
      out_ready  <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_beat(out_status, out_item, out_entries_left, out_last);
  end

  // Drive one command beat and hold it until the block takes it
  task automatic send_cmd(logic [sle_pkg::CMD_W-1:0] cmd,
                          logic signed [sle_pkg::DATA_W-1:0] val);
    if (idle_en && $urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_value <= val;
    do @(posedge clk); while (!in_ready);
    sb.note_command(cmd, val);
  endtask

  // Hold off the sender until every owed beat has arrived
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Small pool for duplicates and hits, extremes, or anything
  function automatic logic signed [sle_pkg::DATA_W-1:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $signed($urandom_range(0, 8)) - 4;
    if (r < 65) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MIN;
        1:       return VAL_MIN + 1;
        2:       return VAL_MAX - 1;
        default: return VAL_MAX;
      endcase
    end
    return $urandom;
  endfunction

  // One random command, mostly well formed, weighted toward inserts
  task automatic random_cmd();
    int r;
    logic signed [sle_pkg::DATA_W-1:0] v;
    r = $urandom_range(0, 99);
    v = ($urandom_range(0, 9) < 6) ? sb.pick_entry() : rand_value();
    if (r < 40)      send_cmd(sle_pkg::CMD_INSERT, rand_value());
    else if (r < 60) send_cmd(sle_pkg::CMD_SEARCH, v);
    else if (r < 82) send_cmd(sle_pkg::CMD_DELETE, v);
    else if (r < 91) send_cmd(sle_pkg::CMD_SHOW, $urandom);
    else if (r < 95) send_cmd(sle_pkg::CMD_CLEAR, $urandom);
    else
      send_cmd(sle_pkg::CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI)), $urandom);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, extremes, duplicates, misses, unknown codes
    send_cmd(sle_pkg::CMD_SHOW,   32'sd0);
    send_cmd(sle_pkg::CMD_CLEAR,  32'sd0);
    send_cmd(sle_pkg::CMD_DELETE, 32'sd5);
    send_cmd(sle_pkg::CMD_SEARCH, 32'sd5);
    send_cmd(sle_pkg::CMD_INSERT, 32'sd0);
    send_cmd(sle_pkg::CMD_INSERT, VAL_MAX);
    send_cmd(sle_pkg::CMD_INSERT, VAL_MIN);
    send_cmd(sle_pkg::CMD_INSERT, -32'sd1);
    send_cmd(sle_pkg::CMD_INSERT, 32'sd0);
    send_cmd(sle_pkg::CMD_INSERT, 32'sd1);
    send_cmd(sle_pkg::CMD_SEARCH, 32'sd0);
    send_cmd(sle_pkg::CMD_SEARCH, VAL_MIN);
    send_cmd(sle_pkg::CMD_SEARCH, VAL_MAX);
    send_cmd(sle_pkg::CMD_SEARCH, 32'sd2);
    send_cmd(sle_pkg::CMD_DELETE, 32'sd0);
    send_cmd(sle_pkg::CMD_DELETE, 32'sd3);
    send_cmd(sle_pkg::CMD_SHOW,   '1);
    for (int u = CMD_UNKNOWN_LO; u <= CMD_UNKNOWN_HI; u++) send_cmd(sle_pkg::CMD_W'(u), '1);
    send_cmd(sle_pkg::CMD_CLEAR,  '1);
    send_cmd(sle_pkg::CMD_SHOW,   32'sd0);

    // Random mix with idling on both sides
    repeat (45) random_cmd();
    drain_results();

    // Fill to capacity, overflow it, dump it, then thin it out
    while (sb.shadow_cnt < CAP) send_cmd(sle_pkg::CMD_INSERT, rand_value());
    repeat (3) send_cmd(sle_pkg::CMD_INSERT, rand_value());
    send_cmd(sle_pkg::CMD_SHOW, $urandom);
    repeat (8) send_cmd(sle_pkg::CMD_DELETE, sb.pick_entry());
    repeat (4) send_cmd(sle_pkg::CMD_SEARCH, rand_value());
    repeat (3) send_cmd(sle_pkg::CMD_INSERT, rand_value());

    // Tail at full rate
    idle_en = 1'b0;
    repeat (30) random_cmd();
    send_cmd(sle_pkg::CMD_CLEAR, $urandom);
    send_cmd(sle_pkg::CMD_SHOW, $urandom);

    drain_results();
    repeat (40) @(posedge clk);
    if (sb.pending() != 0)
      sb.note_fail($sformatf("%0d result beats never arrived", sb.pending()));

    if (sb.fail_cnt == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
